[rtl/rtf_pkg.sv]
// Shared types and constants for the region trajectory filter.
// Used by rtf_ctrl and region_trajectory_filter; depends on nothing.
`default_nettype none

package rtf_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_X_LOW      = 3'd0;
	localparam logic [2:0] REG_X_HIGH     = 3'd1;
	localparam logic [2:0] REG_Y_LOW      = 3'd2;
	localparam logic [2:0] REG_Y_HIGH     = 3'd3;
	localparam logic [2:0] REG_MIN_LENGTH = 3'd4;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MIN_LEN_W = 13;
	localparam int PID_W = 10;
	localparam int LABEL_W = 10;

	localparam logic signed [31:0] X_LOW_RST  = 32'sh8000_0000;
	localparam logic signed [31:0] X_HIGH_RST = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Y_LOW_RST  = 32'sh8000_0000;
	localparam logic signed [31:0] Y_HIGH_RST = 32'sh7FFF_FFFF;
	localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 13'd1;

	typedef struct packed {
		logic signed [31:0]    x_low;
		logic signed [31:0]    x_high;
		logic signed [31:0]    y_low;
		logic signed [31:0]    y_high;
		logic [MIN_LEN_W-1:0]  min_length;
	} cfg_t;

	// one stored row with its in-region bit
	typedef struct packed {
		logic [31:0]      x;
		logic [31:0]      y;
		logic [31:0]      a;
		logic [31:0]      b;
		logic [PID_W-1:0] pid;
		logic             in_region;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LOAD_WR,
		ST_DRAIN,
		ST_DRAIN_CNT,
		ST_DRAIN_CHK,
		ST_END,
		ST_CLEAR
	} state_t;

endpackage

`default_nettype wire

[rtl/rtf_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the row store and the per-particle in-region counts; no dependencies.
`default_nettype none

module rtf_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/rtf_ctrl.sv]
// Sequencer of the region trajectory filter: load, drain, end marker and clearing pass.
// Owns the row and count RAMs (rtf_ram) and the output register; uses rtf_pkg.
`default_nettype none

module rtf_ctrl #(
	parameter int MAX_ROWS = 4096,
	parameter int MAX_PARTICLES = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rtf_pkg::cfg_t                cfg,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [31:0]           pos_x,
	input  wire logic signed [31:0]           pos_y,
	input  wire logic signed [31:0]           aux_a,
	input  wire logic signed [31:0]           aux_b,
	input  wire logic [rtf_pkg::PID_W-1:0]    particle,
	input  wire logic                         func,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [31:0]                out_x,
	output logic signed [31:0]                out_y,
	output logic signed [31:0]                out_aux_a,
	output logic signed [31:0]                out_aux_b,
	output logic [rtf_pkg::LABEL_W-1:0]       new_label,
	output logic                              finished,
	output logic                              overflowed
);

	localparam int AW_R = $clog2(MAX_ROWS);
	localparam int AW_P = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam int CMP_W = (CNT_W > rtf_pkg::MIN_LEN_W) ? CNT_W : rtf_pkg::MIN_LEN_W;
	localparam logic [CNT_W-1:0] ROWS_FULL = CNT_W'(MAX_ROWS);
	localparam logic [AW_P-1:0] CLR_LAST = AW_P'(MAX_PARTICLES - 1);

	rtf_pkg::state_t state_q, state_nxt;

	rtf_pkg::row_t row_q;
	logic [CNT_W-1:0] rows_loaded_q;
	logic [CNT_W-1:0] read_index_q;
	logic [rtf_pkg::LABEL_W-1:0] next_label_q;
	logic prev_valid_q;
	logic [rtf_pkg::PID_W-1:0] prev_particle_q;
	logic drop_flag_q;
	logic [AW_P-1:0] clr_idx_q;

	// memory ports
	logic row_we, row_re;
	logic [AW_R-1:0] row_waddr, row_raddr;
	rtf_pkg::row_t row_wdata, row_rdata;
	logic cnt_we, cnt_re;
	logic [AW_P-1:0] cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

	logic accept;
	logic in_rect;
	logic drop;
	logic has_row;
	logic count_ok;
	logic out_free;
	logic emit_row, emit_end;
	logic new_particle;
	logic [rtf_pkg::LABEL_W-1:0] label_nxt;

	rtf_ram #(.DEPTH(MAX_ROWS), .WIDTH(rtf_pkg::ROW_W)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	rtf_ram #(.DEPTH(MAX_PARTICLES), .WIDTH(CNT_W)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign in_rect = ($signed(row_q.x) >= cfg.x_low) && ($signed(row_q.x) <= cfg.x_high) &&
		($signed(row_q.y) >= cfg.y_low) && ($signed(row_q.y) <= cfg.y_high);
	assign drop = (rows_loaded_q == ROWS_FULL) ||
		(32'(row_q.pid) >= 32'(MAX_PARTICLES));
	assign has_row = read_index_q < rows_loaded_q;
	assign count_ok = CMP_W'(cnt_rdata) >= CMP_W'(cfg.min_length);

	assign new_particle = !prev_valid_q || (prev_particle_q != row_rdata.pid);
	assign label_nxt = (new_particle && prev_valid_q) ? next_label_q + 1'b1 : next_label_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rtf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = func ? rtf_pkg::ST_DRAIN : rtf_pkg::ST_LOAD;
				end
			end
			rtf_pkg::ST_LOAD: begin
				state_nxt = (!drop && in_rect) ? rtf_pkg::ST_LOAD_WR : rtf_pkg::ST_IDLE;
			end
			rtf_pkg::ST_LOAD_WR: begin
				state_nxt = rtf_pkg::ST_IDLE;
			end
			rtf_pkg::ST_DRAIN: begin
				state_nxt = has_row ? rtf_pkg::ST_DRAIN_CNT : rtf_pkg::ST_END;
			end
			rtf_pkg::ST_DRAIN_CNT: begin
				state_nxt = row_rdata.in_region ? rtf_pkg::ST_DRAIN_CHK : rtf_pkg::ST_IDLE;
			end
			rtf_pkg::ST_DRAIN_CHK: begin
				if (!count_ok || out_free) begin
					state_nxt = rtf_pkg::ST_IDLE;
				end
			end
			rtf_pkg::ST_END: begin
				if (out_free) begin
					state_nxt = rtf_pkg::ST_CLEAR;
				end
			end
			rtf_pkg::ST_CLEAR: begin
				if (clr_idx_q == CLR_LAST) begin
					state_nxt = rtf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rtf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		row_we = 1'b0;
		row_re = 1'b0;
		cnt_we = 1'b0;
		cnt_re = 1'b0;
		row_waddr = rows_loaded_q[AW_R-1:0];
		row_raddr = read_index_q[AW_R-1:0];
		row_wdata = row_q;
		row_wdata.in_region = in_rect;
		cnt_raddr = AW_P'(row_q.pid);
		cnt_waddr = AW_P'(row_q.pid);
		cnt_wdata = cnt_rdata + 1'b1;
		emit_row = 1'b0;
		emit_end = 1'b0;
		case (state_q)
			rtf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			rtf_pkg::ST_LOAD: begin
				row_we = !drop;
				cnt_re = !drop && in_rect;
			end
			rtf_pkg::ST_LOAD_WR: begin
				// saturate at the row capacity
				cnt_we = cnt_rdata < ROWS_FULL;
			end
			rtf_pkg::ST_DRAIN: begin
				row_re = has_row;
			end
			rtf_pkg::ST_DRAIN_CNT: begin
				cnt_re = row_rdata.in_region;
				cnt_raddr = AW_P'(row_rdata.pid);
			end
			rtf_pkg::ST_DRAIN_CHK: begin
				emit_row = count_ok && out_free;
			end
			rtf_pkg::ST_END: begin
				emit_end = out_free;
			end
			rtf_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
				cnt_waddr = clr_idx_q;
				cnt_wdata = '0;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtf_pkg::ST_CLEAR;
			rows_loaded_q <= '0;
			read_index_q <= '0;
			next_label_q <= '0;
			prev_valid_q <= 1'b0;
			prev_particle_q <= '0;
			drop_flag_q <= 1'b0;
			clr_idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rtf_pkg::ST_LOAD) begin
				if (drop) begin
					drop_flag_q <= 1'b1;
				end else begin
					rows_loaded_q <= rows_loaded_q + 1'b1;
				end
			end
			if (state_q == rtf_pkg::ST_DRAIN && has_row) begin
				read_index_q <= read_index_q + 1'b1;
			end
			if (emit_row) begin
				next_label_q <= label_nxt;
				prev_valid_q <= 1'b1;
				prev_particle_q <= row_rdata.pid;
			end
			// end marker returns the store to its reset state
			if (emit_end) begin
				rows_loaded_q <= '0;
				read_index_q <= '0;
				next_label_q <= '0;
				prev_valid_q <= 1'b0;
				prev_particle_q <= '0;
				drop_flag_q <= 1'b0;
				clr_idx_q <= '0;
			end
			if (state_q == rtf_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (emit_row || emit_end) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q.x <= pos_x;
			row_q.y <= pos_y;
			row_q.a <= aux_a;
			row_q.b <= aux_b;
			row_q.pid <= particle;
			row_q.in_region <= 1'b0;
		end
		if (emit_row) begin
			out_x <= row_rdata.x;
			out_y <= row_rdata.y;
			out_aux_a <= row_rdata.a;
			out_aux_b <= row_rdata.b;
			new_label <= label_nxt;
			finished <= 1'b0;
			overflowed <= drop_flag_q;
		end else if (emit_end) begin
			out_x <= '0;
			out_y <= '0;
			out_aux_a <= '0;
			out_aux_b <= '0;
			new_label <= '0;
			finished <= 1'b1;
			overflowed <= drop_flag_q;
		end
	end

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == rtf_pkg::ST_DRAIN_CHK ||
			$past(state_q) == rtf_pkg::ST_END))
		else $error("result appeared outside an emitting state");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		read_index_q <= rows_loaded_q)
		else $error("read index passed the loaded row count");

	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_loaded_q <= ROWS_FULL)
		else $error("loaded row count exceeds capacity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end |=> (rows_loaded_q == '0 && read_index_q == '0 && !drop_flag_q &&
			state_q == rtf_pkg::ST_CLEAR))
		else $error("end marker did not return the store to reset");

endmodule

`default_nettype wire

[rtl/region_trajectory_filter.sv]
// Region trajectory filter: holds the configuration registers and the sequencer.
// Depends on rtf_pkg, rtf_ctrl and rtf_ram.
// One item at a time. A drain tick reads the row RAM, then the count RAM; a kept
// row is registered from ST_DRAIN_CHK, an end marker from ST_END, once the output is
// free. An end marker starts a pass that clears every count; reset starts the same
// pass, and no item is accepted until it ends. Configuration is kept on drain.
`default_nettype none

module region_trajectory_filter #(
	parameter int MAX_ROWS = 4096,
	parameter int MAX_PARTICLES = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rtf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rtf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                func,
	input  wire logic signed [31:0]                  pos_x,
	input  wire logic signed [31:0]                  pos_y,
	input  wire logic signed [31:0]                  aux_a,
	input  wire logic signed [31:0]                  aux_b,
	input  wire logic [rtf_pkg::PID_W-1:0]           particle,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [31:0]                       out_x,
	output logic signed [31:0]                       out_y,
	output logic signed [31:0]                       out_aux_a,
	output logic signed [31:0]                       out_aux_b,
	output logic [rtf_pkg::LABEL_W-1:0]              new_label,
	output logic                                     finished,
	output logic                                     overflowed
);

	rtf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low <= rtf_pkg::X_LOW_RST;
			cfg_q.x_high <= rtf_pkg::X_HIGH_RST;
			cfg_q.y_low <= rtf_pkg::Y_LOW_RST;
			cfg_q.y_high <= rtf_pkg::Y_HIGH_RST;
			cfg_q.min_length <= rtf_pkg::MIN_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rtf_pkg::REG_X_LOW:      cfg_q.x_low <= cfg_data;
				rtf_pkg::REG_X_HIGH:     cfg_q.x_high <= cfg_data;
				rtf_pkg::REG_Y_LOW:      cfg_q.y_low <= cfg_data;
				rtf_pkg::REG_Y_HIGH:     cfg_q.y_high <= cfg_data;
				rtf_pkg::REG_MIN_LENGTH: cfg_q.min_length <= cfg_data[rtf_pkg::MIN_LEN_W-1:0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	rtf_ctrl #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.aux_a      (aux_a),
		.aux_b      (aux_b),
		.particle   (particle),
		.func       (func),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_aux_a  (out_aux_a),
		.out_aux_b  (out_aux_b),
		.new_label  (new_label),
		.finished   (finished),
		.overflowed (overflowed)
	);

endmodule

`default_nettype wire
